// ===== src/npcs_pkg.sv =====
`timescale 1ns / 1ps

package npcs_pkg;

  localparam int unsigned PalEntries = 256;
  localparam int unsigned IdxW       = (PalEntries > 1) ? $clog2(PalEntries) : 1;
  localparam int unsigned IdxInW     = 8;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned SqW        = 2 * ChanW;
  localparam int unsigned DistW      = SqW + 2;
  localparam int unsigned ColourW    = 3 * ChanW;

  typedef enum logic [1:0] {
    ActWrite = 2'd0,
    ActMark  = 2'd1,
    ActClear = 2'd2,
    ActQuery = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StWait,
    StDone
  } state_e;

  typedef struct packed {
    logic            vld;
    logic            used;
    logic            last;
    logic [IdxW-1:0] idx;
  } tag_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } colour_t;

endpackage

// ===== src/npcs_dist.sv =====
`timescale 1ns / 1ps

module npcs_dist (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  npcs_pkg::tag_t              tag_i,
  input  npcs_pkg::colour_t           query_i,
  input  npcs_pkg::colour_t           entry_i,
  output npcs_pkg::tag_t              tag_o,
  output logic [npcs_pkg::DistW-1:0]  dist_o
);

  npcs_pkg::tag_t                    tag_a_q, tag_b_q;
  logic [npcs_pkg::SqW-1:0]          sq_r_q, sq_g_q, sq_b_q;
  logic [npcs_pkg::SqW-1:0]          sq_r_d, sq_g_d, sq_b_d;
  logic [npcs_pkg::ChanW-1:0]        dr, dg, db;
  logic [npcs_pkg::DistW-1:0]        sum_q, sum_d;

  always_comb begin
    dr = (query_i.red > entry_i.red) ? (query_i.red - entry_i.red)
                                     : (entry_i.red - query_i.red);
    dg = (query_i.green > entry_i.green) ? (query_i.green - entry_i.green)
                                         : (entry_i.green - query_i.green);
    db = (query_i.blue > entry_i.blue) ? (query_i.blue - entry_i.blue)
                                       : (entry_i.blue - query_i.blue);
    sq_r_d = npcs_pkg::SqW'(dr) * npcs_pkg::SqW'(dr);
    sq_g_d = npcs_pkg::SqW'(dg) * npcs_pkg::SqW'(dg);
    sq_b_d = npcs_pkg::SqW'(db) * npcs_pkg::SqW'(db);
    sum_d  = npcs_pkg::DistW'(sq_r_q) + npcs_pkg::DistW'(sq_g_q) + npcs_pkg::DistW'(sq_b_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_r_q <= sq_r_d;
    sq_g_q <= sq_g_d;
    sq_b_q <= sq_b_d;
    sum_q  <= sum_d;
  end

  assign tag_o  = tag_b_q;
  assign dist_o = sum_q;

endmodule

// ===== src/nearest_palette_color_search_top.sv =====
`timescale 1ns / 1ps

// Nearest palette colour search. Write, mark and clear requests are taken while idle. A query
// walks all 256 palette entries through one shared squared-distance unit, one entry a cycle,
// behind a registered palette memory read and two distance stages; no request is taken during
// the walk. The answer is the lowest index of the used entry nearest the queried colour, or 0
// when no entry is used. The result sits in an output register, so requests are taken while it
// waits.
module nearest_palette_color_search_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  logic [1:0]  s_axis_tuser_i,   // action[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // nearest_index[7:0]
);

  localparam int unsigned CmpW = npcs_pkg::IdxInW + 1;

  npcs_pkg::state_e                  state_q, state_d;
  npcs_pkg::action_e                 action;
  npcs_pkg::colour_t                 in_colour, query_q, rd_data_q;
  npcs_pkg::tag_t                    p1_tag_q, p1_tag_d, dist_tag;
  logic [npcs_pkg::IdxInW-1:0]       entry_index;
  logic [npcs_pkg::IdxW-1:0]         addr_q, addr_d;
  logic [npcs_pkg::PalEntries-1:0]   used_q;
  logic [npcs_pkg::ColourW-1:0]      pal_mem [npcs_pkg::PalEntries];
  logic [npcs_pkg::DistW-1:0]        cand_dist, best_dist_q;
  logic [npcs_pkg::IdxW-1:0]         best_pos_q;
  logic                              found_q;
  logic                              in_acc, in_range, issue, last_issue, take_better;
  logic                              load_out, out_vld_q;
  logic [7:0]                        out_data_q;

  assign action      = npcs_pkg::action_e'(s_axis_tuser_i);
  assign entry_index = s_axis_tdata_i[7:0];
  assign in_colour   = '{red: s_axis_tdata_i[15:8], green: s_axis_tdata_i[23:16],
                         blue: s_axis_tdata_i[31:24]};
  assign in_acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign in_range    = CmpW'(entry_index) < CmpW'(npcs_pkg::PalEntries);
  assign last_issue  = addr_q == npcs_pkg::IdxW'(npcs_pkg::PalEntries - 1);
  assign take_better = dist_tag.vld && dist_tag.used && (!found_q || cand_dist < best_dist_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      npcs_pkg::StIdle: begin
        if (in_acc && action == npcs_pkg::ActQuery) state_d = npcs_pkg::StScan;
      end
      npcs_pkg::StScan: begin
        if (last_issue) state_d = npcs_pkg::StWait;
      end
      npcs_pkg::StWait: begin
        if (dist_tag.vld && dist_tag.last) state_d = npcs_pkg::StDone;
      end
      npcs_pkg::StDone: begin
        if (!out_vld_q || m_axis_tready_i) state_d = npcs_pkg::StIdle;
      end
      default: state_d = npcs_pkg::StIdle;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready_o = 1'b0;
    issue           = 1'b0;
    load_out        = 1'b0;
    case (state_q)
      npcs_pkg::StIdle: s_axis_tready_o = 1'b1;
      npcs_pkg::StScan: issue = 1'b1;
      npcs_pkg::StWait: ;
      npcs_pkg::StDone: load_out = !out_vld_q || m_axis_tready_i;
      default: ;
    endcase
    addr_d        = issue ? addr_q + 1'b1 : '0;
    p1_tag_d.vld  = issue;
    p1_tag_d.used = used_q[addr_q];
    p1_tag_d.last = last_issue;
    p1_tag_d.idx  = addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= npcs_pkg::StIdle;
      addr_q      <= '0;
      p1_tag_q    <= '0;
      used_q      <= '0;
      found_q     <= 1'b0;
      best_dist_q <= '0;
      best_pos_q  <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      p1_tag_q <= p1_tag_d;
      if (in_acc && action == npcs_pkg::ActClear) begin
        used_q <= '0;
      end else if (in_acc && action == npcs_pkg::ActMark && in_range) begin
        used_q[entry_index[npcs_pkg::IdxW-1:0]] <= 1'b1;
      end
      if (in_acc && action == npcs_pkg::ActQuery) begin
        found_q     <= 1'b0;
        best_dist_q <= '0;
        best_pos_q  <= '0;
      end else if (take_better) begin
        found_q     <= 1'b1;
        best_dist_q <= cand_dist;
        best_pos_q  <= dist_tag.idx;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && action == npcs_pkg::ActQuery) query_q <= in_colour;
    if (load_out) out_data_q <= 8'(best_pos_q);
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && action == npcs_pkg::ActWrite && in_range) begin
      pal_mem[entry_index[npcs_pkg::IdxW-1:0]] <= in_colour;
    end
    rd_data_q <= pal_mem[addr_q];
  end

  npcs_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (p1_tag_q),
    .query_i (query_q),
    .entry_i (rd_data_q),
    .tag_o   (dist_tag),
    .dist_o  (cand_dist)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  a_last_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_tag.vld && dist_tag.last |=> state_q == npcs_pkg::StDone)
    else $error("walk did not end after last entry");

  a_idle_no_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == npcs_pkg::StIdle |-> !p1_tag_q.vld && !dist_tag.vld)
    else $error("entry in flight while idle");

  a_none_used_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q |-> best_pos_q == '0 && best_dist_q == '0)
    else $error("answer not zero with no used entry");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == npcs_pkg::StDone))
    else $error("result raised outside the done step");

endmodule
